### hdl/cidr_pkg.sv
`default_nettype none

package cidr_pkg;

  localparam int unsigned IdW        = 11;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned NumBytes   = 8;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned FramesW    = 29;
  localparam int unsigned TailW      = 3;
  localparam int unsigned DataW      = NumBytes * ByteW;

  // Stream beat widths, padded to whole bytes
  localparam int unsigned InFieldsW  = IdW + DataW;
  localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = SizeW + DataW + ByteW + SizeW + SizeW + 3 + ByteW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [IdW-1:0]   StartIdReset = 11'h0A0;
  localparam logic [IdW-1:0]   DataIdReset  = 11'h0A1;
  localparam logic [IdW-1:0]   EndIdReset   = 11'h0A2;
  localparam logic [ByteW-1:0] StartMark    = 8'hAA;
  localparam logic [SizeW-1:0] FrameBytes   = 32'd8;

  typedef enum logic [1:0] {
    CFG_START_ID = 2'd0,
    CFG_DATA_ID  = 2'd1,
    CFG_END_ID   = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

### hdl/can_image_download_receiver_top.sv
// CAN image download receiver, one channel. Each input beat is one received
// standard frame (11-bit identifier plus eight data bytes); each accepted beat
// yields exactly one result beat. A start frame (bytes 0 and 1 = 0xAA, only
// while no header is held) loads the big-endian image size from bytes 4..7.
// A data frame is reported as an 8-byte memory write (tuser = 1) at a running
// offset that advances by 8, and its bytes go into an 8-bit wrapping checksum:
// all eight while full frames remain, otherwise only the tail bytes of the
// image. An end frame latches the sent checksum (byte 6) and corrects the
// received size by byte 7. Identifiers come from three config registers
// (index 0 start, 1 data, 2 end; reset 0xA0/0xA1/0xA2); when several match,
// start wins over data over end, and unmatched frames only report the state.
// Throughput is one frame per clock unless the output stalls; a frame
// passes the input and result registers, with the whole frame update done in
// one pass between them. Write configuration only while the block is idle.
`default_nettype none

module can_image_download_receiver_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Frame input
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // {pad, byte7, ..., byte0, frame_id}: frame_id[10:0], byteN at [18+8N:11+8N]
  input  wire logic [cidr_pkg::InTdataW-1:0]     s_axis_tdata,
  // Result output
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // write_offset[31:0], write_data[95:32], running_checksum[103:96],
  // expected_size[135:104], actual_size[167:136], header_seen[168],
  // transfer_started[169], end_seen[170], sent_checksum[178:171], zero pad
  output logic [cidr_pkg::OutTdataW-1:0]         m_axis_tdata,
  // write_valid[0]
  output logic [0:0]                             m_axis_tuser,
  // Configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [cidr_pkg::IdW-1:0]          cfg_data_i
);

  localparam int unsigned IdW   = cidr_pkg::IdW;
  localparam int unsigned ByteW = cidr_pkg::ByteW;
  localparam int unsigned SizeW = cidr_pkg::SizeW;

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, decode index, ignore unknown ones
  // ---------------------------------------------------------------------------
  logic [IdW-1:0] start_id_q, data_id_q, end_id_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_id_q <= cidr_pkg::StartIdReset;
      data_id_q  <= cidr_pkg::DataIdReset;
      end_id_q   <= cidr_pkg::EndIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cidr_pkg::cfg_idx_e'(cfg_index_i))
        cidr_pkg::CFG_START_ID: start_id_q <= cfg_data_i;
        cidr_pkg::CFG_DATA_ID:  data_id_q  <= cfg_data_i;
        cidr_pkg::CFG_END_ID:   end_id_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. A held frame advances into the result register whenever
  // that register is empty or its beat is taken in the same cycle.
  // ---------------------------------------------------------------------------
  logic                              in_valid_q;
  logic [cidr_pkg::InFieldsW-1:0]    in_data_q;
  logic                              out_valid_q;
  logic                              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[cidr_pkg::InFieldsW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Frame decode
  // ---------------------------------------------------------------------------
  logic [IdW-1:0]               frame_id;
  logic [cidr_pkg::DataW-1:0]   frame_data;
  logic [ByteW-1:0]             frame_byte [cidr_pkg::NumBytes];
  logic                         is_start, is_data, is_end;

  assign frame_id   = in_data_q[IdW-1:0];
  assign frame_data = in_data_q[cidr_pkg::InFieldsW-1:IdW];

  always_comb begin
    for (int i = 0; i < cidr_pkg::NumBytes; i++) begin
      frame_byte[i] = frame_data[i*ByteW +: ByteW];
    end
  end

  // Start match wins, then data, then end
  assign is_start = (frame_id == start_id_q);
  assign is_data  = !is_start && (frame_id == data_id_q);
  assign is_end   = !is_start && !is_data && (frame_id == end_id_q);

  // ---------------------------------------------------------------------------
  // Transfer state
  // ---------------------------------------------------------------------------
  logic                           header_q, header_d;
  logic [SizeW-1:0]               size_exp_q, size_exp_d;
  logic [cidr_pkg::FramesW-1:0]   frames_left_q, frames_left_d;
  logic [cidr_pkg::TailW-1:0]     tail_q, tail_d;
  logic [ByteW-1:0]               sum_q, sum_d;
  logic [SizeW-1:0]               offset_q, offset_d;
  logic [SizeW-1:0]               size_act_q, size_act_d;
  logic [ByteW-1:0]               sent_sum_q, sent_sum_d;
  logic                           started_q, started_d;
  logic                           finished_q, finished_d;

  logic [cidr_pkg::TailW:0]       byte_count;
  logic [ByteW-1:0]               frame_sum;
  logic                           marker_ok;

  assign marker_ok = (frame_byte[0] == cidr_pkg::StartMark) &&
                     (frame_byte[1] == cidr_pkg::StartMark);

  // Count all eight bytes while full frames remain, else only the image tail
  assign byte_count = (frames_left_q != '0) ? (cidr_pkg::TailW+1)'(cidr_pkg::NumBytes)
                                            : {1'b0, tail_q};

  always_comb begin
    frame_sum = '0;
    for (int i = 0; i < cidr_pkg::NumBytes; i++) begin
      if (i < int'(byte_count)) begin
        frame_sum = frame_sum + frame_byte[i];
      end
    end
  end

  always_comb begin
    header_d      = header_q;
    size_exp_d    = size_exp_q;
    frames_left_d = frames_left_q;
    tail_d        = tail_q;
    sum_d         = sum_q;
    offset_d      = offset_q;
    size_act_d    = size_act_q;
    sent_sum_d    = sent_sum_q;
    started_d     = started_q;
    finished_d    = finished_q;
    if (is_start) begin
      // Accept the header once, and only with the marker
      if (!header_q && marker_ok) begin
        header_d      = 1'b1;
        size_exp_d    = {frame_byte[4], frame_byte[5], frame_byte[6], frame_byte[7]};
        frames_left_d = size_exp_d[SizeW-1:cidr_pkg::TailW];
        tail_d        = size_exp_d[cidr_pkg::TailW-1:0];
      end
    end else if (is_data) begin
      started_d  = 1'b1;
      if (frames_left_q != '0) begin
        frames_left_d = frames_left_q - cidr_pkg::FramesW'(1);
      end
      sum_d      = sum_q + frame_sum;
      offset_d   = offset_q + cidr_pkg::FrameBytes;
      size_act_d = size_act_q + cidr_pkg::FrameBytes;
    end else if (is_end) begin
      // Drop the last frame's padding: actual - 8 + valid byte count
      finished_d = 1'b1;
      sent_sum_d = frame_byte[6];
      size_act_d = size_act_q + {{(SizeW-ByteW){1'b0}}, frame_byte[7]} - cidr_pkg::FrameBytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q      <= 1'b0;
      size_exp_q    <= '0;
      frames_left_q <= '0;
      tail_q        <= '0;
      sum_q         <= '0;
      offset_q      <= '0;
      size_act_q    <= '0;
      sent_sum_q    <= '0;
      started_q     <= 1'b0;
      finished_q    <= 1'b0;
    end else if (advance) begin
      header_q      <= header_d;
      size_exp_q    <= size_exp_d;
      frames_left_q <= frames_left_d;
      tail_q        <= tail_d;
      sum_q         <= sum_d;
      offset_q      <= offset_d;
      size_act_q    <= size_act_d;
      sent_sum_q    <= sent_sum_d;
      started_q     <= started_d;
      finished_q    <= finished_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [cidr_pkg::OutFieldsW-1:0] out_fields_d;
  logic [cidr_pkg::OutFieldsW-1:0] out_fields_q;
  logic                            out_write_q;

  // Non-data frames report zero offset and zero data
  assign out_fields_d = {sent_sum_d, finished_d, started_d, header_d, size_act_d,
                         size_exp_d, sum_d,
                         is_data ? frame_data : {cidr_pkg::DataW{1'b0}},
                         is_data ? offset_q   : {SizeW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_fields_q <= out_fields_d;
      out_write_q  <= is_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cidr_pkg::OutTdataW-cidr_pkg::OutFieldsW){1'b0}}, out_fields_q};
  assign m_axis_tuser  = out_write_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Once a header is held it stays until reset
  a_header_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    header_q |=> header_q)
    else $error("header flag cleared");

  // Writes land on 8-byte boundaries
  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q[cidr_pkg::TailW-1:0] == '0)
    else $error("write offset misaligned");

  // A data frame uses up exactly one full frame while any remain
  a_frames_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_data && (frames_left_q != '0) |=>
      frames_left_q == $past(frames_left_q) - cidr_pkg::FramesW'(1))
    else $error("full frame count not decremented");

  // A reported write implies the transfer-started flag in the same beat
  a_write_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[169])
    else $error("write reported without transfer started");

  // The input side never stalls while its register is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled with empty register");

endmodule

`default_nettype wire
